FILE: rtl/bpwx_pkg.sv
// shared types, constants and a byte popcount function for the bit plane weighted xor popcount core
package bpwx_pkg;

   localparam int unsigned WORD_W      = 64;
   localparam int unsigned BYTE_COUNT  = 8;
   localparam int unsigned PLANE_FIELDS = 8;
   localparam int unsigned COUNT_W     = 7;
   localparam int unsigned SCORE_W     = 32;
   localparam int unsigned CFG_W       = 4;
   localparam logic [CFG_W-1:0] PLANE_COUNT_RESET = 4'd8;

   typedef logic [COUNT_W-1:0] lane_count_type;
   typedef logic [SCORE_W-1:0] score_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctrl_type;

   // ones in one byte
   function automatic logic [3:0] byte_ones(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, b[i]};
      end
      return n;
   endfunction

endpackage

FILE: rtl/bit_plane_weighted_xor_popcount_core.sv
// top level: plane lanes side by side feeding the merging stage
// path: the last item of a vector passes the lane register, then the result register that holds the score
// throughput: one item per cycle unless a last item waits, set by the lane register and the merging adder
// a last item waits in the lane register only while an earlier score is still untaken
// reset (synchronous, active high) clears the running sum and valids, plane count to 8
module bit_plane_weighted_xor_popcount_core
   import bpwx_pkg::*;
#(
   parameter int unsigned MAX_PLANES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_plane_count,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [WORD_W-1:0] req_vector_word,
   input  logic [WORD_W-1:0] req_query_plane_0,
   input  logic [WORD_W-1:0] req_query_plane_1,
   input  logic [WORD_W-1:0] req_query_plane_2,
   input  logic [WORD_W-1:0] req_query_plane_3,
   input  logic [WORD_W-1:0] req_query_plane_4,
   input  logic [WORD_W-1:0] req_query_plane_5,
   input  logic [WORD_W-1:0] req_query_plane_6,
   input  logic [WORD_W-1:0] req_query_plane_7,
   input  logic [3:0]       req_valid_bytes,
   input  logic             req_last_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SCORE_W-1:0] rsp_score
);

   logic [CFG_W-1:0]      plane_count_ff, plane_count_in;
   stage_ctrl_type        stage_ff, stage_in;
   logic                  take;
   logic                  accept;
   logic [BYTE_COUNT-1:0] byte_enable;
   logic [WORD_W-1:0]     plane_words [PLANE_FIELDS];
   lane_count_type        counts [MAX_PLANES];

   assign csr_ready      = 1'b1;
   assign plane_count_in = (csr_valid && csr_ready) ? csr_plane_count : plane_count_ff;

   assign plane_words[0] = req_query_plane_0;
   assign plane_words[1] = req_query_plane_1;
   assign plane_words[2] = req_query_plane_2;
   assign plane_words[3] = req_query_plane_3;
   assign plane_words[4] = req_query_plane_4;
   assign plane_words[5] = req_query_plane_5;
   assign plane_words[6] = req_query_plane_6;
   assign plane_words[7] = req_query_plane_7;

   always_comb begin
      for (int b = 0; b < BYTE_COUNT; b++) begin
         byte_enable[b] = (4'(b) < req_valid_bytes);
      end
   end

   assign req_ready = !stage_ff.valid || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      stage_in = stage_ff;
      if (take) begin
         stage_in.valid = 1'b0;
      end
      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.last  = req_last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= PLANE_COUNT_RESET;
         stage_ff       <= '0;
      end else begin
         plane_count_ff <= plane_count_in;
         stage_ff       <= stage_in;
      end
   end

   for (genvar k = 0; k < MAX_PLANES; k++) begin : g_lane
      bpwx_lane u_lane (
         .clock       (clock),
         .load        (accept),
         .active      (4'(k) < plane_count_ff),
         .vector_word (req_vector_word),
         .plane_word  (plane_words[k]),
         .byte_enable (byte_enable),
         .count       (counts[k])
      );
   end

   bpwx_merge #(
      .MAX_PLANES (MAX_PLANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage_ff),
      .counts    (counts),
      .take      (take),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_score (rsp_score)
   );

endmodule

FILE: rtl/bpwx_lane.sv
// one plane lane: masked xor against the vector word and popcount, zero when inactive, registered
module bpwx_lane
   import bpwx_pkg::*;
(
   input  logic                  clock,
   input  logic                  load,
   input  logic                  active,
   input  logic [WORD_W-1:0]     vector_word,
   input  logic [WORD_W-1:0]     plane_word,
   input  logic [BYTE_COUNT-1:0] byte_enable,
   output lane_count_type        count
);

   lane_count_type count_ff;
   lane_count_type count_in;
   logic [WORD_W-1:0] diff;

   assign diff = vector_word ^ plane_word;

   always_comb begin
      count_in = '0;
      for (int b = 0; b < BYTE_COUNT; b++) begin
         if (byte_enable[b]) begin
            count_in = count_in + COUNT_W'(byte_ones(diff[b*8 +: 8]));
         end
      end
      if (!active) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

FILE: rtl/bpwx_merge.sv
// merging stage: weights lane counts, keeps the running sum and holds the result
module bpwx_merge
   import bpwx_pkg::*;
#(
   parameter int unsigned MAX_PLANES = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  stage_ctrl_type stage,
   input  lane_count_type counts [MAX_PLANES],
   output logic           take,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output score_type      rsp_score
);

   score_type running_sum_ff, running_sum_in;
   score_type score_ff, score_in;
   logic      rsp_valid_ff, rsp_valid_in;
   score_type weighted;
   score_type total;
   logic      slot_free;

   always_comb begin
      weighted = '0;
      for (int k = 0; k < MAX_PLANES; k++) begin
         weighted = weighted + (SCORE_W'(counts[k]) << k);
      end
   end

   assign total     = running_sum_ff + weighted;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign take      = stage.valid && (!stage.last || slot_free);

   always_comb begin
      running_sum_in = running_sum_ff;
      score_in       = score_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (take) begin
         if (stage.last) begin
            running_sum_in = '0;
            score_in       = total;
            rsp_valid_in   = 1'b1;
         end else begin
            running_sum_in = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_sum_ff <= running_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      score_ff <= score_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = score_ff;

endmodule
